@@ hw/rtl/mdpvs_pkg.sv @@
`default_nettype none

package mdpvs_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RUN      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FINISH_CHECK = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VALVE_OPEN   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CUR_THRESH   = 4'd3;

	// Register reset values.
	localparam logic [15:0] MAX_RUN_RST      = 16'd36000;
	localparam logic [15:0] FINISH_CHECK_RST = 16'd600;
	localparam logic [15:0] VALVE_OPEN_RST   = 16'd400;
	localparam logic [9:0]  CUR_THRESH_RST   = 10'd100;

	// Sequencing constants.
	localparam logic [16:0] FEEDBACK_DELAY = 17'd30;
	localparam logic [6:0]  DRY_LIMIT      = 7'd100;
	localparam logic [15:0] CNT_MAX        = 16'hFFFF;

	// Drain tank level codes.
	localparam logic [2:0] LVL_EMPTY = 3'd0;
	localparam logic [2:0] LVL_LOW   = 3'd1;
	localparam logic [2:0] LVL_HIGH  = 3'd2;
	localparam logic [2:0] LVL_ERROR = 3'd3;

	// Request codes.
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_KEY  = 1'b1;

	typedef enum logic [1:0] {
		TONE_NONE    = 2'd0,
		TONE_WARNING = 2'd1,
		TONE_SET_ON  = 2'd2,
		TONE_SET_OFF = 2'd3
	} tone_t;

	typedef struct packed {
		logic [15:0] max_run_ticks;
		logic [15:0] finish_check_ticks;
		logic [15:0] valve_open_ticks;
		logic [9:0]  current_threshold;
	} cfg_t;

	typedef struct packed {
		logic        req_type;
		logic        filter_closed;
		logic        pump_fault;
		logic        room_low_fault;
		logic        leak_fault;
		logic        auto_drain_busy;
		logic [2:0]  drain_level;
		logic        room_tank_low;
		logic [9:0]  pump_current;
	} item_t;

	typedef struct packed {
		logic  pump_on;
		logic  valve_on;
		logic  running;
		tone_t tone;
	} res_t;

	typedef struct packed {
		logic        run_flag;
		logic [15:0] run_timer;
		logic        pump;
		logic        valve;
		logic        came_from_high;
		logic [15:0] open_timer;
		logic [15:0] finish_timer;
		logic [6:0]  dry_count;
	} seq_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/mdpvs_if.sv @@
`default_nettype none

// Input channel: one key press or timer tick per word.
interface mdpvs_item_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic       filter_closed;
	logic       pump_fault;
	logic       room_low_fault;
	logic       leak_fault;
	logic       auto_drain_busy;
	logic [2:0] drain_level;
	logic       room_tank_low;
	logic [9:0] pump_current;

	modport source (
		output valid, req_type, filter_closed, pump_fault, room_low_fault,
		       leak_fault, auto_drain_busy, drain_level, room_tank_low, pump_current,
		input  ready
	);
	modport sink (
		input  valid, req_type, filter_closed, pump_fault, room_low_fault,
		       leak_fault, auto_drain_busy, drain_level, room_tank_low, pump_current,
		output ready
	);
endinterface

// Output channel: one result word per input word.
interface mdpvs_res_if;
	logic       valid;
	logic       ready;
	logic       pump_on;
	logic       valve_on;
	logic       running;
	logic [1:0] tone;

	modport source (output valid, pump_on, valve_on, running, tone, input ready);
	modport sink (input valid, pump_on, valve_on, running, tone, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/manual_drain_pump_valve_sequencer_unit.sv @@
// Manual drain pump and valve sequencer.
// The item channel takes one word per key press or timer tick, with the fault
// flags, drain tank level, room tank low level and pump current sample. The
// result channel gives exactly one word per input word: pump and valve drive,
// the run flag and a tone code, all showing the state after that word.
// The configuration port writes one register per cycle with cfg_we high;
// writes must be made only while no word is in flight; the block does not enforce this.
// The result word is registered twice: an accepted word is captured in an input
// register, and when it moves on, the sequencer state and the result register
// update together. One word is accepted per cycle while the receiver takes its
// results; the rate is set by the single state update each word makes.
// When the receiver stalls, the result register holds its word and the input
// register fills; item.ready then drops until the result is taken.
// Reset clears both valid flags, the run state and all timers, and loads the
// register defaults (36000, 600, 400, 100).
`default_nettype none

module manual_drain_pump_valve_sequencer_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire [mdpvs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire [mdpvs_pkg::CFG_DATA_W-1:0]     cfg_data,
	mdpvs_item_if.sink                          item,
	mdpvs_res_if.source                         result
);
	import mdpvs_pkg::*;

	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	item_t      item_s1;
	logic       valid_s1;
	res_t       res_nxt;
	res_t       res_s2;
	logic       valid_s2;
	logic       advance;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_run_ticks      <= MAX_RUN_RST;
			cfg_q.finish_check_ticks <= FINISH_CHECK_RST;
			cfg_q.valve_open_ticks   <= VALVE_OPEN_RST;
			cfg_q.current_threshold  <= CUR_THRESH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_RUN:      cfg_q.max_run_ticks      <= cfg_data;
				REG_FINISH_CHECK: cfg_q.finish_check_ticks <= cfg_data;
				REG_VALVE_OPEN:   cfg_q.valve_open_ticks   <= cfg_data;
				REG_CUR_THRESH:   cfg_q.current_threshold  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves on when the result register is free or being taken.
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.req_type        <= item.req_type;
			item_s1.filter_closed   <= item.filter_closed;
			item_s1.pump_fault      <= item.pump_fault;
			item_s1.room_low_fault  <= item.room_low_fault;
			item_s1.leak_fault      <= item.leak_fault;
			item_s1.auto_drain_busy <= item.auto_drain_busy;
			item_s1.drain_level     <= item.drain_level;
			item_s1.room_tank_low   <= item.room_tank_low;
			item_s1.pump_current    <= item.pump_current;
		end
	end

	mdpvs_step u_step (
		.cur  (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Sequencer state updates once per word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign result.valid    = valid_s2;
	assign result.pump_on  = res_s2.pump_on;
	assign result.valve_on = res_s2.valve_on;
	assign result.running  = res_s2.running;
	assign result.tone     = res_s2.tone;

`ifndef NO_ASSERTIONS
	// Pump and valve are never driven together.
	a_pump_valve_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.pump && state_q.valve))
		else $error("pump and valve both on");

	// The no-water counter stays at or below its limit.
	a_dry_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.dry_count <= DRY_LIMIT)
		else $error("dry count above limit");

	// A word leaving stage 1 always lands in the result register.
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("advanced word lost");

	// Start tone comes only with a running result, stop tone only with a stopped one.
	a_tone_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((res_s2.tone != TONE_SET_ON || res_s2.running) &&
			(res_s2.tone != TONE_SET_OFF || !res_s2.running)))
		else $error("tone disagrees with run flag");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/mdpvs_step.sv @@
`default_nettype none

// Next-state and result logic for one word against the current sequencer state.
module mdpvs_step (
	input  mdpvs_pkg::seq_state_t cur,
	input  mdpvs_pkg::cfg_t       cfg,
	input  mdpvs_pkg::item_t      item,
	output mdpvs_pkg::seq_state_t nxt,
	output mdpvs_pkg::res_t       res
);
	import mdpvs_pkg::*;

	logic        fault;
	logic        dry;
	logic [16:0] open_limit;
	logic [15:0] hold;
	logic [15:0] run_inc;
	logic [15:0] open_inc;
	logic [15:0] finish_inc;
	logic [6:0]  dry_inc;
	tone_t       tone;

	// Shared terms.
	assign fault = !item.filter_closed || item.pump_fault || item.room_low_fault ||
		item.leak_fault || item.auto_drain_busy;
	assign dry        = item.pump_current <= cfg.current_threshold;
	assign open_limit = {1'b0, cfg.valve_open_ticks} + FEEDBACK_DELAY;
	assign hold       = open_limit[16] ? CNT_MAX : open_limit[15:0];
	assign run_inc    = (cur.run_timer == CNT_MAX) ? CNT_MAX : cur.run_timer + 16'd1;
	assign open_inc   = (cur.open_timer == CNT_MAX) ? CNT_MAX : cur.open_timer + 16'd1;
	assign finish_inc = (cur.finish_timer == CNT_MAX) ? CNT_MAX : cur.finish_timer + 16'd1;
	assign dry_inc    = (cur.dry_count >= DRY_LIMIT) ? DRY_LIMIT : cur.dry_count + 7'd1;

	always_comb begin
		nxt  = cur;
		tone = TONE_NONE;
		if (item.req_type == REQ_KEY) begin
			// Key press toggles the run state only; a start with a fault gives a warning instead.
			if (!cur.run_flag) begin
				if (fault) begin
					tone = TONE_WARNING;
				end else begin
					tone         = TONE_SET_ON;
					nxt.run_flag = 1'b1;
				end
			end else begin
				tone         = TONE_SET_OFF;
				nxt.run_flag = 1'b0;
			end
		end else begin
			if (cur.run_flag && fault) begin
				tone = TONE_WARNING;
			end
			if (!cur.run_flag || fault || run_inc >= cfg.max_run_ticks) begin
				// Idle, aborted or out of time: clear all sequencing state.
				nxt = '0;
			end else begin
				nxt.run_timer = run_inc;
				case (item.drain_level)
					LVL_EMPTY: begin
						nxt.pump           = 1'b0;
						nxt.valve          = 1'b1;
						nxt.came_from_high = 1'b0;
						nxt.open_timer     = '0;
						nxt.dry_count      = '0;
						if (item.room_tank_low) begin
							nxt.finish_timer = finish_inc;
							if (finish_inc >= cfg.finish_check_ticks) begin
								// Early finish: next tick ends the run.
								nxt.finish_timer = '0;
								nxt.run_timer    = cfg.max_run_ticks;
							end
						end else begin
							nxt.finish_timer = '0;
						end
					end
					LVL_LOW: begin
						nxt.finish_timer = '0;
						if (!cur.came_from_high) begin
							nxt.open_timer = open_inc;
							if (open_inc >= cfg.valve_open_ticks) begin
								nxt.pump  = 1'b1;
								nxt.valve = 1'b0;
								if ({1'b0, open_inc} >= open_limit) begin
									nxt.open_timer = dry ? 16'd0 : hold;
								end
							end else begin
								nxt.pump  = 1'b0;
								nxt.valve = 1'b1;
							end
						end else begin
							nxt.open_timer = '0;
							if (dry) begin
								nxt.dry_count = dry_inc;
								if (dry_inc >= DRY_LIMIT) begin
									nxt.dry_count = DRY_LIMIT;
									nxt.pump      = 1'b0;
									nxt.valve     = 1'b1;
								end else begin
									nxt.pump  = 1'b1;
									nxt.valve = 1'b0;
								end
							end else begin
								nxt.pump      = 1'b1;
								nxt.valve     = 1'b0;
								nxt.dry_count = '0;
							end
						end
					end
					LVL_HIGH, LVL_ERROR: begin
						nxt.pump           = 1'b1;
						nxt.valve          = 1'b0;
						nxt.came_from_high = 1'b1;
						nxt.dry_count      = '0;
					end
					default: begin
						// Invalid level reading.
						nxt.pump           = 1'b0;
						nxt.valve          = 1'b0;
						nxt.came_from_high = 1'b0;
					end
				endcase
			end
		end
	end

	// Result shows the state after the word.
	always_comb begin
		res.pump_on  = nxt.pump;
		res.valve_on = nxt.valve;
		res.running  = nxt.run_flag;
		res.tone     = tone;
	end

endmodule

`default_nettype wire
